>>> rtl/ogg_page_builder_defines.svh
// Assertion macros shared by the Ogg page builder modules.
`ifndef OGG_PAGE_BUILDER_DEFINES_SVH
`define OGG_PAGE_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define OPB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge, also while reset is applied.
`define OPB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OPB_ASSERT(lbl, prop, msg)
`define OPB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/opb_pkg.sv
// Shared types, constants and functions of the Ogg page builder.
package opb_pkg;

	// Default payload capacity in bytes.
	localparam int PAYLOAD_DEPTH_DEF = 4096;

	// Fixed header length and lacing value limit.
	localparam int FIXED_HDR = 27;
	localparam int LACE_MAX  = 255;

	// Ogg CRC-32 generator polynomial, MSB first.
	localparam logic [31:0] OGG_POLY = 32'h04C11DB7;

	// Capture pattern "OggS".
	localparam logic [7:0] OGG_MAGIC [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};
	localparam logic [7:0] OGG_VERSION = 8'h00;

	// Input item kinds carried on s_tuser.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CRC_RUN,
		S_CRC_TAIL,
		S_READY,
		S_RD_OUT
	} state_t;

	// Kind of result written into the output register.
	typedef enum logic [1:0] {
		RES_REFUSE,
		RES_LOAD,
		RES_READ
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;
		logic save_hdr;
		logic crc_start;
		logic crc_issue;
		logic ptr_inc;
		logic ptr_clr;
		logic page_clr;
		logic out_load;
		res_t res;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic at_last;
	} sts_t;

	// One byte of the Ogg CRC-32, eight shift steps.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h000000};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ((c << 1) ^ OGG_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/opb_dp.sv
// Datapath of the Ogg page builder: payload memory, page walker, CRC and output register.
`include "ogg_page_builder_defines.svh"

module opb_dp #(
	parameter int PAYLOAD_DEPTH = opb_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  opb_pkg::cmd_t    cmd,
	output opb_pkg::sts_t    sts,
	input  logic [7:0]       data_byte,
	input  logic [7:0]       header_type,
	input  logic [63:0]      granule_position,
	input  logic [31:0]      stream_serial,
	input  logic [31:0]      page_sequence,
	output logic             accepted,
	output logic [7:0]       page_byte,
	output logic             byte_valid,
	output logic             page_end,
	output logic             overflow
);

	localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
	localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + 1);
	localparam int SEG_W  = $clog2(PAYLOAD_DEPTH / opb_pkg::LACE_MAX + 2);
	localparam int PTR_W  = $clog2(opb_pkg::FIXED_HDR + PAYLOAD_DEPTH / opb_pkg::LACE_MAX
		+ 1 + PAYLOAD_DEPTH);

	logic [7:0]       mem [PAYLOAD_DEPTH];
	logic [7:0]       rdata_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rem_q;
	logic [SEG_W-1:0] seg_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_s1;
	logic             crc_s1;
	logic [31:0]      crc_q;
	logic [7:0]       type_q;
	logic [63:0]      gran_q;
	logic [31:0]      serial_q;
	logic [31:0]      seq_q;
	logic             accepted_q;
	logic [7:0]       page_byte_q;
	logic             byte_valid_q;
	logic             page_end_q;
	logic             overflow_q;

	logic             full;
	logic [PTR_W-1:0] lace_end;
	logic [PTR_W-1:0] page_last;
	logic [PTR_W-1:0] raddr_full;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]      crc_fld;
	logic [7:0]       hdr [opb_pkg::FIXED_HDR];
	logic [7:0]       cur_byte;

	// Page geometry from the running counters.
	assign full       = (cnt_q == CNT_W'(PAYLOAD_DEPTH));
	assign lace_end   = PTR_W'(opb_pkg::FIXED_HDR) + PTR_W'(seg_q);
	assign page_last  = PTR_W'(opb_pkg::FIXED_HDR - 1) + PTR_W'(seg_q) + PTR_W'(cnt_q);
	assign raddr_full = ptr_q - lace_end;
	assign raddr      = raddr_full[ADDR_W-1:0];

	assign sts.full    = full;
	assign sts.at_last = (ptr_q == page_last);

	// Payload memory: one write port for loads, one registered read port for the walker.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[cnt_q[ADDR_W-1:0]] <= data_byte;
		end
		rdata_s1 <= mem[raddr];
	end

	// The CRC field reads as zero while the checksum is being formed.
	assign crc_fld = crc_s1 ? 32'h0 : crc_q;

	// Fixed header bytes, multi-byte fields little-endian.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hdr[i] = opb_pkg::OGG_MAGIC[i];
		end
		hdr[4] = opb_pkg::OGG_VERSION;
		hdr[5] = type_q;
		for (int i = 0; i < 8; i++) begin
			hdr[6 + i] = gran_q[8*i +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			hdr[14 + i] = serial_q[8*i +: 8];
			hdr[18 + i] = seq_q[8*i +: 8];
			hdr[22 + i] = crc_fld[8*i +: 8];
		end
		hdr[26] = 8'(seg_q);
	end

	// Page byte at the registered walker position, aligned with the memory read data.
	always_comb begin
		if (ptr_s1 < PTR_W'(opb_pkg::FIXED_HDR)) begin
			cur_byte = hdr[ptr_s1[4:0]];
		end else if (ptr_s1 < lace_end) begin
			cur_byte = (ptr_s1 == lace_end - PTR_W'(1)) ? rem_q : 8'(opb_pkg::LACE_MAX);
		end else begin
			cur_byte = rdata_s1;
		end
	end

	// Payload count with its segment count and lacing remainder kept alongside.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
			seg_q <= SEG_W'(1);
		end else if (cmd.page_clr) begin
			cnt_q <= '0;
			rem_q <= '0;
			seg_q <= SEG_W'(1);
		end else if (cmd.store) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (rem_q == 8'(opb_pkg::LACE_MAX - 1)) begin
				rem_q <= '0;
				seg_q <= seg_q + SEG_W'(1);
			end else begin
				rem_q <= rem_q + 8'd1;
			end
		end
	end

	// Walker pointer, shared by the checksum pass and page reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			crc_s1 <= 1'b0;
		end else begin
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			crc_s1 <= cmd.crc_issue;
		end
	end

	always_ff @(posedge clk) begin
		ptr_s1 <= ptr_q;
	end

	// Checksum accumulator, one page byte per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (cmd.crc_start) begin
			crc_q <= '0;
		end else if (crc_s1) begin
			crc_q <= opb_pkg::crc_byte(crc_q, cur_byte);
		end
	end

	// Header fields taken with the closing byte.
	always_ff @(posedge clk) begin
		if (cmd.save_hdr) begin
			type_q   <= header_type;
			gran_q   <= granule_position;
			serial_q <= stream_serial;
			seq_q    <= page_sequence;
		end
	end

	// Output register contents.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res)
				opb_pkg::RES_LOAD: begin
					accepted_q   <= 1'b1;
					page_byte_q  <= '0;
					byte_valid_q <= 1'b0;
					page_end_q   <= 1'b0;
					overflow_q   <= full;
				end
				opb_pkg::RES_READ: begin
					accepted_q   <= 1'b1;
					page_byte_q  <= cur_byte;
					byte_valid_q <= 1'b1;
					page_end_q   <= sts.at_last;
					overflow_q   <= 1'b0;
				end
				default: begin
					accepted_q   <= 1'b0;
					page_byte_q  <= '0;
					byte_valid_q <= 1'b0;
					page_end_q   <= 1'b0;
					overflow_q   <= 1'b0;
				end
			endcase
		end
	end

	assign accepted   = accepted_q;
	assign page_byte  = page_byte_q;
	assign byte_valid = byte_valid_q;
	assign page_end   = page_end_q;
	assign overflow   = overflow_q;

	`OPB_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(PAYLOAD_DEPTH), "payload count beyond capacity")
	`OPB_ASSERT(a_rem_bound, rem_q < 8'(opb_pkg::LACE_MAX), "lacing remainder out of range")
	`OPB_ASSERT(a_no_store_full, cmd.store |-> !full, "store issued into a full payload memory")

endmodule

>>> rtl/opb_ctrl.sv
// Controller of the Ogg page builder: phase state machine and handshakes.
`include "ogg_page_builder_defines.svh"

module opb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             action,
	input  logic             last,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  opb_pkg::sts_t    sts,
	output opb_pkg::cmd_t    cmd
);

	opb_pkg::state_t state_q;
	opb_pkg::state_t state_nxt;
	logic            m_tvalid_q;
	logic            slot_free;
	logic            take;
	logic            is_load;

	// The output register is free when empty or drained in this cycle.
	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = slot_free && (state_q == opb_pkg::S_IDLE || state_q == opb_pkg::S_READY);
	assign take      = s_tvalid && s_tready;
	assign is_load   = (action == opb_pkg::ACT_LOAD);
	assign m_tvalid  = m_tvalid_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			opb_pkg::S_IDLE: begin
				if (take && is_load && last) begin
					state_nxt = opb_pkg::S_CRC_RUN;
				end
			end
			opb_pkg::S_CRC_RUN: begin
				if (sts.at_last) begin
					state_nxt = opb_pkg::S_CRC_TAIL;
				end
			end
			opb_pkg::S_CRC_TAIL: begin
				state_nxt = opb_pkg::S_READY;
			end
			opb_pkg::S_READY: begin
				if (take && !is_load) begin
					state_nxt = opb_pkg::S_RD_OUT;
				end
			end
			opb_pkg::S_RD_OUT: begin
				state_nxt = sts.at_last ? opb_pkg::S_IDLE : opb_pkg::S_READY;
			end
			default: begin
				state_nxt = opb_pkg::S_IDLE;
			end
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd.store     = 1'b0;
		cmd.save_hdr  = 1'b0;
		cmd.crc_start = 1'b0;
		cmd.crc_issue = 1'b0;
		cmd.ptr_inc   = 1'b0;
		cmd.ptr_clr   = 1'b0;
		cmd.page_clr  = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.res       = opb_pkg::RES_REFUSE;
		case (state_q)
			opb_pkg::S_IDLE: begin
				if (take) begin
					cmd.out_load = 1'b1;
					if (is_load) begin
						cmd.res       = opb_pkg::RES_LOAD;
						cmd.store     = !sts.full;
						cmd.save_hdr  = last;
						cmd.crc_start = last;
						cmd.ptr_clr   = last;
					end
				end
			end
			opb_pkg::S_CRC_RUN: begin
				cmd.crc_issue = 1'b1;
				cmd.ptr_inc   = !sts.at_last;
			end
			opb_pkg::S_CRC_TAIL: begin
				cmd.ptr_clr = 1'b1;
			end
			opb_pkg::S_READY: begin
				// A load in this phase is refused; a read moves to the read-out state for the memory.
				if (take && is_load) begin
					cmd.out_load = 1'b1;
				end
			end
			opb_pkg::S_RD_OUT: begin
				cmd.out_load = 1'b1;
				cmd.res      = opb_pkg::RES_READ;
				cmd.ptr_inc  = !sts.at_last;
				cmd.ptr_clr  = sts.at_last;
				cmd.page_clr = sts.at_last;
			end
			default: begin
				cmd.res = opb_pkg::RES_REFUSE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= opb_pkg::S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`OPB_ASSERT(a_busy_no_ready,
		(state_q == opb_pkg::S_CRC_RUN || state_q == opb_pkg::S_CRC_TAIL) |-> !s_tready,
		"input taken during the checksum pass")
	`OPB_ASSERT(a_tail_to_ready, state_q == opb_pkg::S_CRC_TAIL |=> state_q == opb_pkg::S_READY,
		"checksum pass did not end in the ready phase")
	`OPB_ASSERT(a_rd_out_slot, state_q == opb_pkg::S_RD_OUT |-> slot_free,
		"read result found the output register occupied")
	`OPB_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> state_q == opb_pkg::S_IDLE,
		"controller not idle after reset")

endmodule

>>> rtl/ogg_page_builder.sv
// Top level of the Ogg page builder: controller plus datapath.
//
// Builds one Ogg page around a packet. Load items (s_tuser low) store one payload byte each;
// the load with s_tlast set also takes the header type, granule position, serial and sequence
// and closes the page. Read items (s_tuser high) then return the page bytes in order: the
// 27-byte header with its CRC-32, the lacing table and the payload. Every item gets exactly
// one result; an item in the wrong phase is refused with all result flags low, and a load
// into a full payload memory is dropped with the overflow flag set. A load or refused item
// gets its result in the output register directly; a read first passes the read-out state,
// set by the registered read port of the payload memory. Closing a page runs a checksum pass
// over the header, lacing table and payload, one page byte per cycle through that same read
// port, during which no item is taken. The payload memory needs no clearing after reset.
module ogg_page_builder #(
	parameter int PAYLOAD_DEPTH = opb_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// [7:0] data_byte, [15:8] header_type, [79:16] granule_position,
	// [111:80] stream_serial, [143:112] page_sequence
	input  logic [143:0]  s_tdata,
	input  logic          s_tlast,
	// [0] action
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// [7:0] page_byte
	output logic [7:0]    m_tdata,
	output logic          m_tlast,
	// [0] accepted, [1] byte_valid, [2] overflow
	output logic [2:0]    m_tuser
);

	opb_pkg::cmd_t cmd;
	opb_pkg::sts_t sts;
	logic          accepted;
	logic          byte_valid;
	logic          overflow;

	opb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.last     (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	opb_dp #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.data_byte        (s_tdata[7:0]),
		.header_type      (s_tdata[15:8]),
		.granule_position (s_tdata[79:16]),
		.stream_serial    (s_tdata[111:80]),
		.page_sequence    (s_tdata[143:112]),
		.accepted         (accepted),
		.page_byte        (m_tdata),
		.byte_valid       (byte_valid),
		.page_end         (m_tlast),
		.overflow         (overflow)
	);

	assign m_tuser = {overflow, byte_valid, accepted};

endmodule
